/* rtl/ale_pkg.sv */
// Package for the array list engine: field widths, command and status codes,
// and the control/status structs between controller and datapath.
// No dependencies.
package ale_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_AT    = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_AT    = 3'd4,
    CMD_DEL_BACK  = 3'd5,
    CMD_READ      = 3'd6,
    CMD_FIND      = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_INS  = 3'd1,
    OP_DEL  = 3'd2,
    OP_DROP = 3'd3,
    OP_READ = 3'd4,
    OP_FIND = 3'd5
  } op_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic more;
    logic slot_free;
  } sts_t;

endpackage

/* rtl/ale_ifs.sv */
// Request and response channel interfaces of the array list engine.
// Depends on ale_pkg for field widths.
interface ale_req_if;
  logic                        valid;
  logic                        ready;
  logic [ale_pkg::CMD_W-1:0]   cmd;
  logic [ale_pkg::POS_W-1:0]   position;
  logic signed [ale_pkg::DATA_W-1:0] item_value;

  modport source (output valid, cmd, position, item_value, input ready);
  modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface ale_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ale_pkg::STAT_W-1:0]  status;
  logic signed [ale_pkg::DATA_W-1:0] read_value;
  logic [ale_pkg::FIDX_W-1:0]  found_index;
  logic [ale_pkg::CNT_W-1:0]   entry_count;

  modport source (output valid, status, read_value, found_index, entry_count, input ready);
  modport sink   (input valid, status, read_value, found_index, entry_count, output ready);
endinterface

/* rtl/ale_datapath.sv */
// Datapath of the array list engine: list memory, count, index and result registers.
// Depends on ale_pkg; driven by ale_controller through ctrl_t / sts_t.
module ale_datapath #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ale_pkg::ctrl_t                 ctrl,
  output ale_pkg::sts_t                  sts,
  input  logic [ale_pkg::CMD_W-1:0]      cmd,
  input  logic [ale_pkg::POS_W-1:0]      position,
  input  logic [ale_pkg::DATA_W-1:0]     item_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ale_pkg::STAT_W-1:0]     status,
  output logic [ale_pkg::DATA_W-1:0]     read_value,
  output logic [ale_pkg::FIDX_W-1:0]     found_index,
  output logic [ale_pkg::CNT_W-1:0]      entry_count
);
  import ale_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_W-1:0] mem [LIST_DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] val;
  logic [DATA_W-1:0] rval;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_load, idx_m1, idx_p1;
  logic [CW-1:0]     tgt, tgt_load;
  logic [PW-1:0]     pos_w, count_w;
  op_t               op, op_load;
  status_t           stat, stat_load, stat_final;
  logic              got, hit, match;
  logic              we;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic [CW+FIDX_W-1:0] fidx_ext;
  logic [CW+CNT_W-1:0]  cnt_ext;

  assign pos_w   = PW'(position);
  assign count_w = PW'(count);
  assign idx_m1  = idx - CW'(1);
  assign idx_p1  = idx + CW'(1);
  assign match   = (rdata == val);

  always_comb begin
    op_load   = OP_NONE;
    stat_load = ST_OK;
    idx_load  = '0;
    tgt_load  = '0;
    unique case (cmd_t'(cmd))
      CMD_INS_FRONT, CMD_INS_AT, CMD_INS_BACK: begin
        priority if (count == CW'(LIST_DEPTH)) begin
          stat_load = ST_FULL;
        end else if (cmd_t'(cmd) == CMD_INS_FRONT || count == '0) begin
          op_load  = OP_INS;
          idx_load = count;
        end else if (cmd_t'(cmd) == CMD_INS_BACK) begin
          op_load  = OP_INS;
          idx_load = count;
          tgt_load = count;
        end else if (pos_w > count_w) begin
          stat_load = ST_BADIDX;
        end else begin
          op_load  = OP_INS;
          idx_load = count;
          tgt_load = pos_w[CW-1:0];
        end
      end
      CMD_DEL_FRONT, CMD_DEL_AT, CMD_DEL_BACK: begin
        priority if (count == '0) begin
          stat_load = ST_EMPTY;
        end else if (cmd_t'(cmd) == CMD_DEL_FRONT) begin
          op_load = OP_DEL;
        end else if (cmd_t'(cmd) == CMD_DEL_BACK) begin
          op_load = OP_DROP;
        end else if (pos_w >= count_w) begin
          stat_load = ST_BADIDX;
        end else begin
          op_load  = OP_DEL;
          idx_load = pos_w[CW-1:0];
        end
      end
      CMD_READ: begin
        if (pos_w >= count_w) begin
          stat_load = ST_BADIDX;
        end else begin
          op_load  = OP_READ;
          idx_load = pos_w[CW-1:0];
        end
      end
      CMD_FIND: begin
        if (count == '0) begin
          stat_load = ST_EMPTY;
        end else begin
          op_load = OP_FIND;
        end
      end
    endcase
  end

  always_comb begin
    unique case (op)
      OP_INS:  sts.more = (idx > tgt);
      OP_DEL:  sts.more = (idx_p1 < count);
      OP_READ: sts.more = !got;
      OP_FIND: sts.more = !hit && (idx < count);
      default: sts.more = 1'b0;
    endcase
    sts.slot_free = !out_valid || out_ready;
  end

  always_comb begin
    unique case (op)
      OP_INS:  raddr = idx_m1[AW-1:0];
      OP_DEL:  raddr = idx_p1[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  assign we    = (ctrl.step && (op == OP_INS || op == OP_DEL)) ||
                 (ctrl.finish && op == OP_INS);
  assign waddr = ctrl.finish ? tgt[AW-1:0] : idx[AW-1:0];
  assign wdata = ctrl.finish ? val : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    count_next = count;
    if (ctrl.finish && op == OP_INS) begin
      count_next = count + CW'(1);
    end else if (ctrl.finish && (op == OP_DEL || op == OP_DROP)) begin
      count_next = count - CW'(1);
    end
  end

  assign stat_final = (op == OP_FIND) ? (hit ? ST_OK : ST_NOTFOUND) : stat;
  assign fidx_ext   = {{FIDX_W{1'b0}}, idx};
  assign cnt_ext    = {{CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op   <= op_load;
      stat <= stat_load;
      idx  <= idx_load;
      tgt  <= tgt_load;
      val  <= item_value;
      rval <= '0;
      got  <= 1'b0;
      hit  <= 1'b0;
    end else if (ctrl.step) begin
      unique case (op)
        OP_INS: idx <= idx_m1;
        OP_DEL: idx <= idx_p1;
        OP_READ: begin
          rval <= rdata;
          got  <= 1'b1;
        end
        OP_FIND: begin
          if (match) begin
            hit <= 1'b1;
          end else begin
            idx <= idx_p1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      status      <= stat_final;
      read_value  <= rval;
      found_index <= (op == OP_FIND && hit) ? fidx_ext[FIDX_W-1:0] : '0;
      entry_count <= cnt_ext[CNT_W-1:0];
    end
  end

endmodule

/* rtl/ale_controller.sv */
// Controller state machine of the array list engine.
// Depends on ale_pkg; sequences ale_datapath through ctrl_t / sts_t.
module ale_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ale_pkg::sts_t  sts,
  output ale_pkg::ctrl_t ctrl
);
  import ale_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_STEP  = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready    = (state == S_IDLE);
  assign ctrl.load   = in_valid && in_ready;
  assign ctrl.step   = (state == S_STEP);
  assign ctrl.finish = (state == S_CHECK) && !sts.more && sts.slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctrl.load) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.more) begin
          state_next = S_STEP;
        end else if (sts.slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_STEP: state_next = S_CHECK;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/array_list_engine_unit.sv */
// Top level of the array list engine: bounded ordered list in a single-port-write memory.
// Depends on ale_pkg, ale_ifs, ale_controller and ale_datapath.
//
// Usage: commands arrive on the request channel (cmd, position, item_value) and each
// gives exactly one transaction on the response channel (status, read_value,
// found_index, entry_count). Both channels use valid/ready; a transaction moves
// at a clock edge with valid and ready high.
// One command is worked on at a time. With n entries in the list, an error,
// delete-back or append moves no entries before the response is loaded; inserts
// and deletes move k entries one by one, a read makes one memory access and a
// find compares up to n entries in order. Each moved or searched entry costs one
// memory read and one write or compare, set by the memory's registered read port.
// The next request is taken the cycle after the response is loaded, not before.
// The response register frees the engine from the receiver: it accepts the next
// request while an earlier response waits; a finished command holds only until
// the response register is free. Synchronous reset empties the list; memory
// contents are not cleared and need no clearing pass.
module array_list_engine_unit #(
  parameter int LIST_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  ale_req_if.sink   request,
  ale_rsp_if.source response
);
  import ale_pkg::*;

  ctrl_t ctrl;
  sts_t  sts;
  logic  in_ready;

  assign request.ready = in_ready;

  ale_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  ale_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .sts         (sts),
    .cmd         (request.cmd),
    .position    (request.position),
    .item_value  (request.item_value),
    .out_ready   (response.ready),
    .out_valid   (response.valid),
    .status      (response.status),
    .read_value  (response.read_value),
    .found_index (response.found_index),
    .entry_count (response.entry_count)
  );

endmodule
